// File: rtl/tmc_pkg.sv
// shared types, constants and command codes of the two-wheel motion controller
// no dependencies; used by tmc_tick_target, tmc_wall_steer and the top level
package tmc_pkg;

    localparam int COUNT_WIDTH_DEFAULT = 16;

    localparam int CMD_W    = 3;
    localparam int CELLS_W  = 5;
    localparam int DIST_W   = 12;
    localparam int GOAL_W   = 10;
    localparam int SPEED_W  = 9;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 12;

    // forward goal is cells * cell_goal
    localparam int FGOAL_W  = CELLS_W + GOAL_W;

    // goal * 8 / 45 == (goal * RECIP) >> RECIP_SHIFT, exact for all FGOAL_W-bit goals
    localparam int RECIP_W     = 25;
    localparam int RECIP_SHIFT = 27;
    localparam logic [RECIP_W-1:0] RECIP = 25'd23860930;
    localparam int PROD_W      = FGOAL_W + RECIP_W;
    localparam int TICK_W      = PROD_W - RECIP_SHIFT;

    // steering arithmetic width, holds base plus twice a sensor difference
    localparam int STEER_W = DIST_W + 3;

    localparam logic signed [SPEED_W-1:0] SPEED_BASE  = 9'sd120;
    localparam logic signed [SPEED_W-1:0] SPEED_LEFT  = 9'sd120;
    localparam logic signed [SPEED_W-1:0] SPEED_RIGHT = 9'sd130;
    localparam logic signed [SPEED_W-1:0] SPEED_LIMIT = 9'sd200;

    localparam logic [GOAL_W-1:0] CELL_GOAL_RST    = 10'd253;
    localparam logic [GOAL_W-1:0] QUARTER_GOAL_RST = 10'd67;
    localparam logic [GOAL_W-1:0] HALF_GOAL_RST    = 10'd141;
    localparam logic [DIST_W-1:0] BRAKE_NEAR_RST   = 12'd10;
    localparam logic [DIST_W-1:0] BRAKE_FAR_RST    = 12'd60;
    localparam logic [DIST_W-1:0] WALL_LIMIT_RST   = 12'd140;
    localparam logic [DIST_W-1:0] WALL_CENTER_RST  = 12'd60;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CELL_GOAL    = 3'd0,
        REG_QUARTER_GOAL = 3'd1,
        REG_HALF_GOAL    = 3'd2,
        REG_BRAKE_NEAR   = 3'd3,
        REG_BRAKE_FAR    = 3'd4,
        REG_WALL_LIMIT   = 3'd5,
        REG_WALL_CENTER  = 3'd6
    } reg_idx_t;

    typedef enum logic [CMD_W-1:0] {
        CMD_TURN_LEFT  = 3'd0,
        CMD_TURN_RIGHT = 3'd1,
        CMD_TURN_BACK  = 3'd2,
        CMD_FORWARD    = 3'd3,
        CMD_SENSOR     = 3'd4,
        CMD_LEFT_EDGE  = 3'd5,
        CMD_RIGHT_EDGE = 3'd6
    } cmd_t;

    typedef struct packed {
        logic                        brake;
        logic signed [SPEED_W-1:0]   speed;
    } steer_t;

endpackage

// File: rtl/tmc_tick_target.sv
// converts an armed goal into an encoder tick count, goal * 8 / 45 truncated
// uses tmc_pkg for widths and the reciprocal constant
module tmc_tick_target (
    input  logic [tmc_pkg::FGOAL_W-1:0] goal,
    output logic [tmc_pkg::TICK_W-1:0]  ticks
);

    logic [tmc_pkg::PROD_W-1:0] prod;

    // reciprocal multiply, the low bits are the dropped fraction
    assign prod  = tmc_pkg::PROD_W'(goal) * tmc_pkg::PROD_W'(tmc_pkg::RECIP);
    assign ticks = prod[tmc_pkg::RECIP_SHIFT +: tmc_pkg::TICK_W];

endmodule

// File: rtl/tmc_wall_steer.sv
// brake window check and wall-centering left speed for a sensor update
// uses tmc_pkg for widths, speed constants and the steer_t result
module tmc_wall_steer (
    input  logic [tmc_pkg::DIST_W-1:0] dist_front,
    input  logic [tmc_pkg::DIST_W-1:0] dist_left,
    input  logic [tmc_pkg::DIST_W-1:0] dist_right,
    input  logic [tmc_pkg::DIST_W-1:0] brake_near,
    input  logic [tmc_pkg::DIST_W-1:0] brake_far,
    input  logic [tmc_pkg::DIST_W-1:0] wall_limit,
    input  logic [tmc_pkg::DIST_W-1:0] wall_center,
    output tmc_pkg::steer_t            steer
);

    localparam int W = tmc_pkg::STEER_W;

    logic [tmc_pkg::DIST_W:0] side_sum;
    logic signed [W-1:0]      s_left;
    logic signed [W-1:0]      s_right;
    logic signed [W-1:0]      s_center;
    logic signed [W-1:0]      diff;
    logic signed [W-1:0]      off;
    logic signed [W-1:0]      raw;

    assign s_left   = $signed(W'(dist_left));
    assign s_right  = $signed(W'(dist_right));
    assign s_center = $signed(W'(wall_center));
    assign side_sum = {1'b0, dist_left} + {1'b0, dist_right};

    always_comb begin
        diff = '0;
        off  = '0;
        if (side_sum < {1'b0, wall_limit}) begin
            // both walls close: steer toward the middle
            off = s_right - s_left;
        end else if (dist_left < wall_limit) begin
            diff = s_center - s_left;
            off  = {diff[W-2:0], 1'b0};
        end else if (dist_right < wall_limit) begin
            diff = s_right - s_center;
            off  = {diff[W-2:0], 1'b0};
        end
        raw = W'(tmc_pkg::SPEED_BASE) + off;
    end

    always_comb begin
        steer.brake = (dist_front > brake_near) && (dist_front < brake_far);
        if (raw > W'(tmc_pkg::SPEED_LIMIT)) begin
            steer.speed = tmc_pkg::SPEED_LIMIT;
        end else if (raw < -W'(tmc_pkg::SPEED_LIMIT)) begin
            steer.speed = -tmc_pkg::SPEED_LIMIT;
        end else begin
            steer.speed = raw[tmc_pkg::SPEED_W-1:0];
        end
    end

endmodule

// File: rtl/two_wheel_motion_controller.sv
// two-wheel motion controller top level: input register, motion state, result register
// uses tmc_pkg, tmc_tick_target and tmc_wall_steer
//
// Takes one item per clock: a turn or forward command, a sensor update or an encoder
// edge (s_tuser holds the command code), and returns one result item per input with
// both wheel speeds in signed half-percent, the stop flag and the brake flag. An item
// is held in the input register after the edge that accepts it and is written into the
// result register when the result side can take it, and its result is then offered
// from there. A new item is taken every cycle while the result side keeps up. The longest
// path is in the edge update: the tick target multiply on the stored goal followed by
// the count compare. Turn and forward commands latch their goal, so later register
// writes do not move an armed target.
// Register writes take effect at the next edge and are meant for idle periods.
module two_wheel_motion_controller #(
    parameter int COUNT_WIDTH = tmc_pkg::COUNT_WIDTH_DEFAULT
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // cmd/data input
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // [4:0] cells, [16:5] dist_front, [28:17] dist_left, [40:29] dist_right,
    // [41] enc_a, [42] enc_b, [47:43] zero
    input  logic [47:0]                        s_tdata,
    // [2:0] cmd
    input  logic [tmc_pkg::CMD_W-1:0]          s_tuser,
    // result output
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [8:0] left drive, [17:9] right drive, [18] stopped, [19] braked, [23:20] zero
    output logic [23:0]                        m_tdata,
    // register write port
    input  logic                               cfg_wr_en,
    input  logic [tmc_pkg::CFG_IDX_W-1:0]      cfg_addr,
    input  logic [tmc_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    localparam int SW = tmc_pkg::SPEED_W;
    localparam int DW = tmc_pkg::DIST_W;
    localparam int GW = tmc_pkg::GOAL_W;

    // configuration registers
    logic [GW-1:0] cell_goal_reg;
    logic [GW-1:0] quarter_goal_reg;
    logic [GW-1:0] half_goal_reg;
    logic [DW-1:0] brake_near_reg;
    logic [DW-1:0] brake_far_reg;
    logic [DW-1:0] wall_limit_reg;
    logic [DW-1:0] wall_center_reg;

    // input register
    logic                         in_valid_reg;
    tmc_pkg::cmd_t                in_cmd_reg;
    logic [tmc_pkg::CELLS_W-1:0]  in_cells_reg;
    logic [DW-1:0]                in_front_reg;
    logic [DW-1:0]                in_left_reg;
    logic [DW-1:0]                in_right_reg;
    logic                         in_a_reg;
    logic                         in_b_reg;

    // motion state
    logic [COUNT_WIDTH-1:0]       left_count_reg, left_count_next;
    logic [COUNT_WIDTH-1:0]       right_count_reg, right_count_next;
    logic [tmc_pkg::FGOAL_W-1:0]  goal_reg, goal_next;
    logic                         left_neg_reg, left_neg_next;
    logic                         right_neg_reg, right_neg_next;
    logic                         left_armed_reg, left_armed_next;
    logic                         right_armed_reg, right_armed_next;
    logic signed [SW-1:0]         left_drive_reg, left_drive_next;
    logic signed [SW-1:0]         right_drive_reg, right_drive_next;
    logic                         halted_reg, halted_next;
    logic                         braked_next;

    // result register
    logic                         out_valid_reg;
    logic signed [SW-1:0]         out_left_reg;
    logic signed [SW-1:0]         out_right_reg;
    logic                         out_stopped_reg;
    logic                         out_braked_reg;

    logic                         advance;
    logic                         fire;
    logic                         s_accept;
    logic [tmc_pkg::TICK_W-1:0]   ticks;
    logic [COUNT_WIDTH-1:0]       ticks_w;
    logic [COUNT_WIDTH-1:0]       left_target;
    logic [COUNT_WIDTH-1:0]       right_target;
    tmc_pkg::steer_t              steer;

    assign advance  = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_braked_reg, out_stopped_reg, out_right_reg, out_left_reg};

    tmc_tick_target u_tick_target (
        .goal  (goal_reg),
        .ticks (ticks)
    );

    tmc_wall_steer u_wall_steer (
        .dist_front  (in_front_reg),
        .dist_left   (in_left_reg),
        .dist_right  (in_right_reg),
        .brake_near  (brake_near_reg),
        .brake_far   (brake_far_reg),
        .wall_limit  (wall_limit_reg),
        .wall_center (wall_center_reg),
        .steer       (steer)
    );

    // targets wrap into the count width
    assign ticks_w      = COUNT_WIDTH'(ticks);
    assign left_target  = left_neg_reg  ? -ticks_w : ticks_w;
    assign right_target = right_neg_reg ? -ticks_w : ticks_w;

    always_comb begin
        left_count_next  = left_count_reg;
        right_count_next = right_count_reg;
        goal_next        = goal_reg;
        left_neg_next    = left_neg_reg;
        right_neg_next   = right_neg_reg;
        left_armed_next  = left_armed_reg;
        right_armed_next = right_armed_reg;
        left_drive_next  = left_drive_reg;
        right_drive_next = right_drive_reg;
        halted_next      = halted_reg;
        braked_next      = 1'b0;

        case (in_cmd_reg)
            tmc_pkg::CMD_TURN_LEFT,
            tmc_pkg::CMD_TURN_RIGHT,
            tmc_pkg::CMD_TURN_BACK,
            tmc_pkg::CMD_FORWARD: begin
                left_count_next  = '0;
                right_count_next = '0;
                halted_next      = 1'b0;
                case (in_cmd_reg)
                    tmc_pkg::CMD_TURN_LEFT: begin
                        goal_next        = tmc_pkg::FGOAL_W'(quarter_goal_reg);
                        left_neg_next    = 1'b1;
                        right_neg_next   = 1'b0;
                        left_drive_next  = -tmc_pkg::SPEED_LEFT;
                        right_drive_next = tmc_pkg::SPEED_RIGHT;
                    end
                    tmc_pkg::CMD_TURN_RIGHT: begin
                        goal_next        = tmc_pkg::FGOAL_W'(quarter_goal_reg);
                        left_neg_next    = 1'b0;
                        right_neg_next   = 1'b1;
                        left_drive_next  = tmc_pkg::SPEED_LEFT;
                        right_drive_next = -tmc_pkg::SPEED_RIGHT;
                    end
                    tmc_pkg::CMD_TURN_BACK: begin
                        goal_next        = tmc_pkg::FGOAL_W'(half_goal_reg);
                        left_neg_next    = 1'b1;
                        right_neg_next   = 1'b0;
                        left_drive_next  = -tmc_pkg::SPEED_LEFT;
                        right_drive_next = tmc_pkg::SPEED_RIGHT;
                    end
                    default: begin
                        goal_next        = tmc_pkg::FGOAL_W'(in_cells_reg)
                                         * tmc_pkg::FGOAL_W'(cell_goal_reg);
                        left_neg_next    = 1'b0;
                        right_neg_next   = 1'b0;
                        left_drive_next  = tmc_pkg::SPEED_LEFT;
                        right_drive_next = tmc_pkg::SPEED_RIGHT;
                    end
                endcase
                left_armed_next  = (goal_next != '0);
                right_armed_next = (goal_next != '0);
            end
            tmc_pkg::CMD_SENSOR: begin
                if (steer.brake) begin
                    braked_next      = 1'b1;
                    left_drive_next  = '0;
                    right_drive_next = '0;
                    left_armed_next  = 1'b0;
                    right_armed_next = 1'b0;
                    halted_next      = 1'b1;
                end else begin
                    left_drive_next  = steer.speed;
                end
            end
            tmc_pkg::CMD_LEFT_EDGE: begin
                left_count_next = (in_a_reg != in_b_reg) ? left_count_reg + COUNT_WIDTH'(1)
                                                         : left_count_reg - COUNT_WIDTH'(1);
                if (left_armed_reg && (left_count_next == left_target)) begin
                    left_drive_next  = '0;
                    right_drive_next = '0;
                    left_armed_next  = 1'b0;
                    right_armed_next = 1'b0;
                    halted_next      = 1'b1;
                end
            end
            tmc_pkg::CMD_RIGHT_EDGE: begin
                right_count_next = (in_a_reg != in_b_reg) ? right_count_reg + COUNT_WIDTH'(1)
                                                          : right_count_reg - COUNT_WIDTH'(1);
                if (right_armed_reg && (right_count_next == right_target)) begin
                    left_drive_next  = '0;
                    right_drive_next = '0;
                    left_armed_next  = 1'b0;
                    right_armed_next = 1'b0;
                    halted_next      = 1'b1;
                end
            end
            default: begin
                // unused code: report current state
            end
        endcase
    end

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cell_goal_reg    <= tmc_pkg::CELL_GOAL_RST;
            quarter_goal_reg <= tmc_pkg::QUARTER_GOAL_RST;
            half_goal_reg    <= tmc_pkg::HALF_GOAL_RST;
            brake_near_reg   <= tmc_pkg::BRAKE_NEAR_RST;
            brake_far_reg    <= tmc_pkg::BRAKE_FAR_RST;
            wall_limit_reg   <= tmc_pkg::WALL_LIMIT_RST;
            wall_center_reg  <= tmc_pkg::WALL_CENTER_RST;
        end else if (cfg_wr_en) begin
            case (tmc_pkg::reg_idx_t'(cfg_addr))
                tmc_pkg::REG_CELL_GOAL:    cell_goal_reg    <= cfg_wdata[GW-1:0];
                tmc_pkg::REG_QUARTER_GOAL: quarter_goal_reg <= cfg_wdata[GW-1:0];
                tmc_pkg::REG_HALF_GOAL:    half_goal_reg    <= cfg_wdata[GW-1:0];
                tmc_pkg::REG_BRAKE_NEAR:   brake_near_reg   <= cfg_wdata[DW-1:0];
                tmc_pkg::REG_BRAKE_FAR:    brake_far_reg    <= cfg_wdata[DW-1:0];
                tmc_pkg::REG_WALL_LIMIT:   wall_limit_reg   <= cfg_wdata[DW-1:0];
                tmc_pkg::REG_WALL_CENTER:  wall_center_reg  <= cfg_wdata[DW-1:0];
                default: begin
                end
            endcase
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_accept) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
        if (s_accept) begin
            in_cmd_reg   <= tmc_pkg::cmd_t'(s_tuser);
            in_cells_reg <= s_tdata[4:0];
            in_front_reg <= s_tdata[16:5];
            in_left_reg  <= s_tdata[28:17];
            in_right_reg <= s_tdata[40:29];
            in_a_reg     <= s_tdata[41];
            in_b_reg     <= s_tdata[42];
        end
    end

    // motion state and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_count_reg  <= '0;
            right_count_reg <= '0;
            left_neg_reg    <= 1'b0;
            right_neg_reg   <= 1'b0;
            left_armed_reg  <= 1'b0;
            right_armed_reg <= 1'b0;
            left_drive_reg  <= '0;
            right_drive_reg <= '0;
            halted_reg      <= 1'b1;
            out_valid_reg   <= 1'b0;
        end else begin
            if (fire) begin
                left_count_reg  <= left_count_next;
                right_count_reg <= right_count_next;
                left_neg_reg    <= left_neg_next;
                right_neg_reg   <= right_neg_next;
                left_armed_reg  <= left_armed_next;
                right_armed_reg <= right_armed_next;
                left_drive_reg  <= left_drive_next;
                right_drive_reg <= right_drive_next;
                halted_reg      <= halted_next;
                out_valid_reg   <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg   <= 1'b0;
            end
        end
        if (fire) begin
            goal_reg        <= goal_next;
            out_left_reg    <= left_drive_next;
            out_right_reg   <= right_drive_next;
            out_stopped_reg <= halted_next;
            out_braked_reg  <= braked_next;
        end
    end

`ifndef SYNTHESIS
    a_halt_disarms: assert property (@(posedge aclk) disable iff (!aresetn)
        halted_reg |-> (!left_armed_reg && !right_armed_reg && right_drive_reg == '0))
        else $error("halted with a wheel armed or right wheel driven");

    a_armed_goal: assert property (@(posedge aclk) disable iff (!aresetn)
        (left_armed_reg || right_armed_reg) |-> (goal_reg != '0))
        else $error("wheel armed with a zero goal");

    a_brake_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_braked_reg) |->
            (out_stopped_reg && out_left_reg == '0 && out_right_reg == '0))
        else $error("brake result without a full stop");

    a_fire_result: assert property (@(posedge aclk) disable iff (!aresetn)
        fire |=> out_valid_reg)
        else $error("processed item produced no result");
`endif

endmodule
